// ----- rtl/core/bir_pkg.sv -----
package bir_pkg;

   // Frame store geometry.
   localparam int MAX_SRC_WIDTH  = 256;
   localparam int MAX_SRC_HEIGHT = 256;
   localparam int MAX_DST_DIM    = 4096;
   localparam int STORE_DEPTH    = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int ADDR_W         = $clog2(STORE_DEPTH);

   // Field and register widths.
   localparam int SRC_COORD_W = 8;
   localparam int DST_COORD_W = 12;
   localparam int SRC_DIM_W   = 9;
   localparam int DST_DIM_W   = 13;
   localparam int CH_CNT_W    = 3;
   localparam int PIX_W       = 32;
   localparam int STATUS_W    = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 13;

   // Fixed-point arithmetic.
   localparam int CH_NUM    = 4;
   localparam int CH_W      = 8;
   localparam int FRAC_W    = 8;
   localparam int RATIO_W   = SRC_COORD_W + 16;
   localparam int PROD_W    = DST_COORD_W + RATIO_W;
   localparam int LANE_W    = 11;
   localparam int NB_NUM    = 4;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 3'd4;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CHANNELS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

   // Request kinds.
   localparam logic REQ_LOAD    = 1'b0;
   localparam logic REQ_COMPUTE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_RD,
      ST_HORZ,
      ST_VERT,
      ST_DONE
   } state_type;

   typedef logic [LANE_W-1:0] lane_val_type;

   typedef struct packed {
      logic              h_en;
      logic              v_en;
      logic [FRAC_W-1:0] fx;
      logic [FRAC_W-1:0] fy;
   } lane_ctl_type;

endpackage

// ----- rtl/core/bir_ram.sv -----
module bir_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/bir_divider.sv -----
// Restoring divider, one quotient bit per cycle.
module bir_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [bir_pkg::RATIO_W-1:0]      dividend,
   input  logic [bir_pkg::DST_DIM_W-1:0]    divisor,
   output logic                             busy,
   output logic [bir_pkg::RATIO_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(bir_pkg::RATIO_W);

   logic                           busy_ff, busy_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [bir_pkg::RATIO_W-1:0]    quo_ff, quo_in;
   logic [bir_pkg::DST_DIM_W-1:0]  rem_ff, rem_in;
   logic [bir_pkg::DST_DIM_W-1:0]  div_ff, div_in;
   logic [bir_pkg::DST_DIM_W:0]    shifted;
   logic [bir_pkg::DST_DIM_W:0]    diff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      shifted = {rem_ff, quo_ff[bir_pkg::RATIO_W-1]};
      diff    = shifted - {1'b0, div_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         // The dividend shifts out of the top while quotient bits enter below.
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = diff[bir_pkg::DST_DIM_W-1:0];
            quo_in = {quo_ff[bir_pkg::RATIO_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[bir_pkg::DST_DIM_W-1:0];
            quo_in = {quo_ff[bir_pkg::RATIO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(bir_pkg::RATIO_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/core/bir_lane.sv -----
// One color channel: horizontal blend of both rows, then vertical blend.
module bir_lane (
   input  logic                            clock,
   input  bir_pkg::lane_ctl_type           ctl,
   input  logic [bir_pkg::CH_W-1:0]        tl,
   input  logic [bir_pkg::CH_W-1:0]        tr,
   input  logic [bir_pkg::CH_W-1:0]        bl,
   input  logic [bir_pkg::CH_W-1:0]        br,
   output bir_pkg::lane_val_type           value
);

   localparam int WGT_W = bir_pkg::FRAC_W + 1;
   localparam int HSUM_W = bir_pkg::CH_W + WGT_W;
   localparam int HOUT_W = HSUM_W - bir_pkg::FRAC_W;
   localparam int VSUM_W = HOUT_W + WGT_W + 1;

   logic [WGT_W-1:0]   wx_inv, wy_inv;
   logic [HSUM_W-1:0]  top_sum, bot_sum;
   logic [VSUM_W-1:0]  v_sum;
   logic [HOUT_W-1:0]  top_ff, top_in, bot_ff, bot_in;
   bir_pkg::lane_val_type v_ff, v_in;

   always_comb begin
      wx_inv  = WGT_W'(1 << bir_pkg::FRAC_W) - WGT_W'(ctl.fx);
      wy_inv  = WGT_W'(1 << bir_pkg::FRAC_W) - WGT_W'(ctl.fy);
      top_sum = HSUM_W'(tl) * HSUM_W'(wx_inv) + HSUM_W'(tr) * HSUM_W'(ctl.fx);
      bot_sum = HSUM_W'(bl) * HSUM_W'(wx_inv) + HSUM_W'(br) * HSUM_W'(ctl.fx);
      top_in  = ctl.h_en ? top_sum[HSUM_W-1:bir_pkg::FRAC_W] : top_ff;
      bot_in  = ctl.h_en ? bot_sum[HSUM_W-1:bir_pkg::FRAC_W] : bot_ff;
      v_sum   = VSUM_W'(top_ff) * VSUM_W'(wy_inv) + VSUM_W'(bot_ff) * VSUM_W'(ctl.fy);
      v_in    = ctl.v_en ? bir_pkg::LANE_W'(v_sum >> bir_pkg::FRAC_W) : v_ff;
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      bot_ff <= bot_in;
      v_ff   <= v_in;
   end

   assign value = v_ff;

endmodule

// ----- rtl/core/bir_merge.sv -----
// Clamps each lane to one byte and packs the active channels.
module bir_merge (
   input  bir_pkg::lane_val_type            lane_val [bir_pkg::CH_NUM],
   input  logic [bir_pkg::CH_CNT_W-1:0]     ch_count,
   output logic [bir_pkg::PIX_W-1:0]        pixel
);

   localparam logic [bir_pkg::LANE_W-1:0] CH_MAX = bir_pkg::LANE_W'((1 << bir_pkg::CH_W) - 1);

   always_comb begin
      pixel = '0;
      for (int c = 0; c < bir_pkg::CH_NUM; c++) begin
         if (bir_pkg::CH_CNT_W'(c) < ch_count) begin
            if (lane_val[c] > CH_MAX) begin
               pixel[c*bir_pkg::CH_W +: bir_pkg::CH_W] = CH_MAX[bir_pkg::CH_W-1:0];
            end else begin
               pixel[c*bir_pkg::CH_W +: bir_pkg::CH_W] = lane_val[c][bir_pkg::CH_W-1:0];
            end
         end
      end
   end

endmodule

// ----- rtl/core/bilinear_image_resize.sv -----
// Load transactions are taken one per cycle when not stalled and write the frame store directly.
// A compute transaction runs the multiply, four neighbor reads on the one store port, two
// blend steps and the output load; a status error goes straight to the output load. No
// request is taken until the result is loaded, and a stalled earlier result holds that load.
// Reset and size writes restart the serial ratio dividers; requests stall until they finish.
// Reset restores the register defaults; the frame store is not cleared.
module bilinear_image_resize (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_type,
   input  logic [bir_pkg::SRC_COORD_W-1:0]     req_src_x,
   input  logic [bir_pkg::SRC_COORD_W-1:0]     req_src_y,
   input  logic [bir_pkg::PIX_W-1:0]           req_pixel_in,
   input  logic [bir_pkg::DST_COORD_W-1:0]     req_dst_x,
   input  logic [bir_pkg::DST_COORD_W-1:0]     req_dst_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bir_pkg::PIX_W-1:0]           rsp_pixel_out,
   output logic [bir_pkg::STATUS_W-1:0]        rsp_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bir_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bir_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int SW = bir_pkg::SRC_DIM_W;
   localparam int DW = bir_pkg::DST_DIM_W;
   localparam int CW = bir_pkg::SRC_COORD_W;
   localparam int AHI_W = bir_pkg::PROD_W - 2 * bir_pkg::FRAC_W;
   localparam int NB_IDX_W = $clog2(bir_pkg::NB_NUM);
   localparam int RD_CNT_W = NB_IDX_W + 1;

   // Configuration registers.
   logic [SW-1:0]                   src_width_ff, src_width_in;
   logic [SW-1:0]                   src_height_ff, src_height_in;
   logic [DW-1:0]                   dst_width_ff, dst_width_in;
   logic [DW-1:0]                   dst_height_ff, dst_height_in;
   logic [bir_pkg::CH_CNT_W-1:0]    ch_count_ff, ch_count_in;
   logic                            stale_ff, stale_in;

   logic [SW-1:0] sw_eff, sh_eff;
   logic [DW-1:0] dw_eff, dh_eff;

   // Item and datapath registers.
   bir_pkg::state_type              state_ff, state_in;
   logic [bir_pkg::DST_COORD_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [bir_pkg::CH_CNT_W-1:0]    nch_ff, nch_in;
   logic [bir_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic [bir_pkg::PROD_W-1:0]      prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic [RD_CNT_W-1:0]             rd_cnt_ff, rd_cnt_in;
   logic [bir_pkg::PIX_W-1:0]       nb_ff [bir_pkg::NB_NUM];
   logic [bir_pkg::PIX_W-1:0]       nb_in [bir_pkg::NB_NUM];

   // Output register.
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bir_pkg::PIX_W-1:0]       rsp_pixel_ff, rsp_pixel_in;
   logic [bir_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;

   // Control from the state machine.
   logic req_accept, csr_write, size_write;
   logic div_start, mul_en, rd_en, out_load;
   bir_pkg::lane_ctl_type lane_ctl;

   logic                            div_x_busy, div_y_busy;
   logic [bir_pkg::RATIO_W-1:0]     ratio_x, ratio_y;
   logic [bir_pkg::RATIO_W-1:0]     dividend_x, dividend_y;

   logic [CW-1:0] x1, x2, y1, y2;
   logic [SW-1:0] x1_inc, y1_inc;
   logic [SW-1:0] sw_m1, sh_m1;

   logic                            ch_ok, coord_ok, load_ok;
   logic                            ram_we;
   logic [bir_pkg::ADDR_W-1:0]      ram_waddr, ram_raddr;
   logic [bir_pkg::PIX_W-1:0]       ram_rdata;
   logic [CW-1:0]                   rd_x, rd_y;

   bir_pkg::lane_val_type           lane_val [bir_pkg::CH_NUM];
   logic [bir_pkg::PIX_W-1:0]       merged_pixel;

   // Effective sizes, saturated into their legal ranges.
   always_comb begin
      sw_eff = (src_width_ff == '0) ? SW'(1) :
               (src_width_ff > SW'(bir_pkg::MAX_SRC_WIDTH)) ? SW'(bir_pkg::MAX_SRC_WIDTH) :
               src_width_ff;
      sh_eff = (src_height_ff == '0) ? SW'(1) :
               (src_height_ff > SW'(bir_pkg::MAX_SRC_HEIGHT)) ? SW'(bir_pkg::MAX_SRC_HEIGHT) :
               src_height_ff;
      dw_eff = (dst_width_ff == '0) ? DW'(1) :
               (dst_width_ff > DW'(bir_pkg::MAX_DST_DIM)) ? DW'(bir_pkg::MAX_DST_DIM) :
               dst_width_ff;
      dh_eff = (dst_height_ff == '0) ? DW'(1) :
               (dst_height_ff > DW'(bir_pkg::MAX_DST_DIM)) ? DW'(bir_pkg::MAX_DST_DIM) :
               dst_height_ff;
      sw_m1  = sw_eff - SW'(1);
      sh_m1  = sh_eff - SW'(1);
      dividend_x = {sw_m1[CW-1:0], 16'd0};
      dividend_y = {sh_m1[CW-1:0], 16'd0};
   end

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid & csr_ready;
   assign size_write = csr_write & (csr_index <= bir_pkg::CSR_DST_HEIGHT);

   always_comb begin
      src_width_in  = src_width_ff;
      src_height_in = src_height_ff;
      dst_width_in  = dst_width_ff;
      dst_height_in = dst_height_ff;
      ch_count_in   = ch_count_ff;
      if (csr_write) begin
         case (csr_index)
            bir_pkg::CSR_SRC_WIDTH:     src_width_in  = csr_wdata[SW-1:0];
            bir_pkg::CSR_SRC_HEIGHT:    src_height_in = csr_wdata[SW-1:0];
            bir_pkg::CSR_DST_WIDTH:     dst_width_in  = csr_wdata[DW-1:0];
            bir_pkg::CSR_DST_HEIGHT:    dst_height_in = csr_wdata[DW-1:0];
            bir_pkg::CSR_CHANNEL_COUNT: ch_count_in   = csr_wdata[bir_pkg::CH_CNT_W-1:0];
            default: ;
         endcase
      end
      // A size write during a recompute forces another pass afterward.
      if (size_write) begin
         stale_in = 1'b1;
      end else if (div_start) begin
         stale_in = 1'b0;
      end else begin
         stale_in = stale_ff;
      end
   end

   bir_divider u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend_x),
      .divisor  (dw_eff),
      .busy     (div_x_busy),
      .quotient (ratio_x)
   );

   bir_divider u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend_y),
      .divisor  (dh_eff),
      .busy     (div_y_busy),
      .quotient (ratio_y)
   );

   assign req_stall  = (state_ff != bir_pkg::ST_IDLE) | stale_ff;
   assign req_accept = req_valid & ~req_stall;

   assign ch_ok    = (ch_count_ff == bir_pkg::CH_CNT_W'(3)) |
                     (ch_count_ff == bir_pkg::CH_CNT_W'(4));
   assign coord_ok = (DW'(req_dst_x) < dw_eff) & (DW'(req_dst_y) < dh_eff);
   assign load_ok  = (SW'(req_src_x) < sw_eff) & (SW'(req_src_y) < sh_eff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bir_pkg::ST_IDLE: begin
            if (stale_ff) begin
               state_in = bir_pkg::ST_DIV;
            end else if (req_accept && req_type == bir_pkg::REQ_COMPUTE) begin
               state_in = (ch_ok && coord_ok) ? bir_pkg::ST_MUL : bir_pkg::ST_DONE;
            end
         end
         bir_pkg::ST_DIV: begin
            if (!div_x_busy && !div_y_busy) begin
               state_in = bir_pkg::ST_IDLE;
            end
         end
         bir_pkg::ST_MUL:  state_in = bir_pkg::ST_RD;
         bir_pkg::ST_RD: begin
            if (rd_cnt_ff == RD_CNT_W'(bir_pkg::NB_NUM)) begin
               state_in = bir_pkg::ST_HORZ;
            end
         end
         bir_pkg::ST_HORZ: state_in = bir_pkg::ST_VERT;
         bir_pkg::ST_VERT: state_in = bir_pkg::ST_DONE;
         bir_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = bir_pkg::ST_IDLE;
            end
         end
         default: state_in = bir_pkg::ST_IDLE;
      endcase
   end

   // State machine outputs.
   always_comb begin
      div_start     = 1'b0;
      mul_en        = 1'b0;
      rd_en         = 1'b0;
      out_load      = 1'b0;
      lane_ctl.h_en = 1'b0;
      lane_ctl.v_en = 1'b0;
      lane_ctl.fx   = prod_x_ff[2*bir_pkg::FRAC_W-1:bir_pkg::FRAC_W];
      lane_ctl.fy   = prod_y_ff[2*bir_pkg::FRAC_W-1:bir_pkg::FRAC_W];
      case (state_ff)
         bir_pkg::ST_IDLE: div_start     = stale_ff;
         bir_pkg::ST_MUL:  mul_en        = 1'b1;
         bir_pkg::ST_RD:   rd_en         = 1'b1;
         bir_pkg::ST_HORZ: lane_ctl.h_en = 1'b1;
         bir_pkg::ST_VERT: lane_ctl.v_en = 1'b1;
         bir_pkg::ST_DONE: out_load      = ~rsp_valid_ff | ~rsp_stall;
         default: ;
      endcase
   end

   // Integer indices of the neighbors; the near index and the far neighbor clamp to the last column or row.
   always_comb begin
      if (prod_x_ff[bir_pkg::PROD_W-1:2*bir_pkg::FRAC_W] > AHI_W'(sw_m1)) begin
         x1 = sw_m1[CW-1:0];
      end else begin
         x1 = prod_x_ff[2*bir_pkg::FRAC_W +: CW];
      end
      if (prod_y_ff[bir_pkg::PROD_W-1:2*bir_pkg::FRAC_W] > AHI_W'(sh_m1)) begin
         y1 = sh_m1[CW-1:0];
      end else begin
         y1 = prod_y_ff[2*bir_pkg::FRAC_W +: CW];
      end
      x1_inc = SW'(x1) + SW'(1);
      y1_inc = SW'(y1) + SW'(1);
      x2 = (x1_inc < sw_eff) ? x1_inc[CW-1:0] : sw_m1[CW-1:0];
      y2 = (y1_inc < sh_eff) ? y1_inc[CW-1:0] : sh_m1[CW-1:0];
      // Read order: top left, top right, bottom left, bottom right.
      rd_x = rd_cnt_ff[0] ? x2 : x1;
      rd_y = rd_cnt_ff[1] ? y2 : y1;
   end

   assign ram_we    = req_accept & (req_type == bir_pkg::REQ_LOAD) & load_ok;
   assign ram_waddr = bir_pkg::ADDR_W'(req_src_y) * bir_pkg::ADDR_W'(bir_pkg::MAX_SRC_WIDTH)
                      + bir_pkg::ADDR_W'(req_src_x);
   assign ram_raddr = bir_pkg::ADDR_W'(rd_y) * bir_pkg::ADDR_W'(bir_pkg::MAX_SRC_WIDTH)
                      + bir_pkg::ADDR_W'(rd_x);

   bir_ram #(
      .WIDTH (bir_pkg::PIX_W),
      .DEPTH (bir_pkg::STORE_DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_pixel_in),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Datapath register updates.
   always_comb begin
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      nch_in    = nch_ff;
      status_in = status_ff;
      prod_x_in = prod_x_ff;
      prod_y_in = prod_y_ff;
      rd_cnt_in = rd_cnt_ff;
      for (int i = 0; i < bir_pkg::NB_NUM; i++) begin
         nb_in[i] = nb_ff[i];
      end
      if (req_accept && req_type == bir_pkg::REQ_COMPUTE) begin
         dx_in  = req_dst_x;
         dy_in  = req_dst_y;
         nch_in = ch_count_ff;
         if (!ch_ok) begin
            status_in = bir_pkg::STATUS_CHANNELS;
         end else if (!coord_ok) begin
            status_in = bir_pkg::STATUS_RANGE;
         end else begin
            status_in = bir_pkg::STATUS_OK;
         end
      end
      if (mul_en) begin
         prod_x_in = bir_pkg::PROD_W'(dx_ff) * bir_pkg::PROD_W'(ratio_x);
         prod_y_in = bir_pkg::PROD_W'(dy_ff) * bir_pkg::PROD_W'(ratio_y);
         rd_cnt_in = '0;
      end
      if (rd_en) begin
         rd_cnt_in = rd_cnt_ff + 1'b1;
         // Read data arrives in the cycle after its address.
         if (rd_cnt_ff != '0) begin
            nb_in[NB_IDX_W'(rd_cnt_ff - 1'b1)] = ram_rdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bir_pkg::ST_IDLE;
         stale_ff      <= 1'b1;
         src_width_ff  <= SW'(256);
         src_height_ff <= SW'(256);
         dst_width_ff  <= DW'(256);
         dst_height_ff <= DW'(256);
         ch_count_ff   <= bir_pkg::CH_CNT_W'(4);
         rsp_valid_ff  <= 1'b0;
         rd_cnt_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         stale_ff      <= stale_in;
         src_width_ff  <= src_width_in;
         src_height_ff <= src_height_in;
         dst_width_ff  <= dst_width_in;
         dst_height_ff <= dst_height_in;
         ch_count_ff   <= ch_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         rd_cnt_ff     <= rd_cnt_in;
      end
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      nch_ff        <= nch_in;
      status_ff     <= status_in;
      prod_x_ff     <= prod_x_in;
      prod_y_ff     <= prod_y_in;
      nb_ff         <= nb_in;
      rsp_pixel_ff  <= rsp_pixel_in;
      rsp_status_ff <= rsp_status_in;
   end

   // One lane per channel.
   for (genvar c = 0; c < bir_pkg::CH_NUM; c++) begin : g_lane
      bir_lane u_lane (
         .clock (clock),
         .ctl   (lane_ctl),
         .tl    (nb_ff[0][c*bir_pkg::CH_W +: bir_pkg::CH_W]),
         .tr    (nb_ff[1][c*bir_pkg::CH_W +: bir_pkg::CH_W]),
         .bl    (nb_ff[2][c*bir_pkg::CH_W +: bir_pkg::CH_W]),
         .br    (nb_ff[3][c*bir_pkg::CH_W +: bir_pkg::CH_W]),
         .value (lane_val[c])
      );
   end

   bir_merge u_merge (
      .lane_val (lane_val),
      .ch_count (nch_ff),
      .pixel    (merged_pixel)
   );

   always_comb begin
      rsp_pixel_in  = rsp_pixel_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_pixel_in  = (status_ff == bir_pkg::STATUS_OK) ? merged_pixel : '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// ----- dv/bilinear_image_resize_test.sv -----
module bilinear_image_resize_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 500_000;
   localparam int SETTLE_CYCLES = 20;

   typedef struct {
      logic                            kind;
      logic [bir_pkg::SRC_COORD_W-1:0] sx;
      logic [bir_pkg::SRC_COORD_W-1:0] sy;
      logic [bir_pkg::PIX_W-1:0]       pix;
      logic [bir_pkg::DST_COORD_W-1:0] dx;
      logic [bir_pkg::DST_COORD_W-1:0] dy;
      bit                              calm;
   } resize_req_type;

   typedef struct {
      logic [bir_pkg::PIX_W-1:0]    pixel;
      logic [bir_pkg::STATUS_W-1:0] status;
   } pixel_result_type;

   typedef struct {
      int sw;
      int sh;
      int dw;
      int dh;
      int ch;
      int count;
   } phase_type;

   // Raw register values; several are out of range on purpose and rely on masking and
   // saturation inside the block.
   phase_type phase_plan [10] = '{
      '{4, 3, 9, 7, 3, 220},
      '{0, 1, 5, 4096, 4, 120},
      '{511, 512, 1, 8191, 4, 150},
      '{16, 16, 16, 16, 0, 60},
      '{256, 256, 4096, 4096, 3, 220},
      '{7, 200, 3, 300, 7, 40},
      '{37, 29, 13, 50, 9, 40},
      '{37, 29, 13, 50, 4, 300},
      '{256, 256, 0, 2, 4, 100},
      '{8, 8, 8, 8, 4, 150}
   };

   logic                            clock         = 1'b0;
   logic                            reset         = 1'b1;
   logic                            req_valid     = 1'b0;
   logic                            req_stall;
   logic                            req_type      = bir_pkg::REQ_LOAD;
   logic [bir_pkg::SRC_COORD_W-1:0] req_src_x     = '0;
   logic [bir_pkg::SRC_COORD_W-1:0] req_src_y     = '0;
   logic [bir_pkg::PIX_W-1:0]       req_pixel_in  = '0;
   logic [bir_pkg::DST_COORD_W-1:0] req_dst_x     = '0;
   logic [bir_pkg::DST_COORD_W-1:0] req_dst_y     = '0;
   logic                            rsp_valid;
   logic                            rsp_stall     = 1'b0;
   logic [bir_pkg::PIX_W-1:0]       rsp_pixel_out;
   logic [bir_pkg::STATUS_W-1:0]    rsp_status;
   logic                            csr_valid     = 1'b0;
   logic                            csr_ready;
   logic [bir_pkg::CSR_IDX_W-1:0]   csr_index     = '0;
   logic [bir_pkg::CSR_DATA_W-1:0]  csr_wdata     = '0;

   // Register copies, as the block holds them after reset.
   logic [bir_pkg::SRC_DIM_W-1:0]   cfg_src_w = 9'd256;
   logic [bir_pkg::SRC_DIM_W-1:0]   cfg_src_h = 9'd256;
   logic [bir_pkg::DST_DIM_W-1:0]   cfg_dst_w = 13'd256;
   logic [bir_pkg::DST_DIM_W-1:0]   cfg_dst_h = 13'd256;
   logic [bir_pkg::CH_CNT_W-1:0]    cfg_ch    = 3'd4;

   logic [bir_pkg::PIX_W-1:0]       frame_copy [bir_pkg::STORE_DEPTH];
   bit                              loaded [bir_pkg::STORE_DEPTH];

   resize_req_type                  request_queue [$];
   pixel_result_type                expected_pixels [$];
   resize_req_type                  cur_req;
   pixel_result_type                want;

   int                              gap_left;
   int                              hold_left;
   int                              error_count = 0;
   int                              cycle_count = 0;
   int                              items_pushed = 0;
   bit                              gen_calm = 1'b0;
   bit                              calm_tail = 1'b0;

   bilinear_image_resize dut (.*);

   always #6ns clock = ~clock;

   function automatic int unsigned eff_size(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic bit channels_ok();
      return cfg_ch == 3'd3 || cfg_ch == 3'd4;
   endfunction

   // Source index pair and 8-bit fraction for destination coordinate d along one axis.
   function automatic void axis_map(input int unsigned d, input int unsigned s,
                                    input int unsigned dd, output int unsigned lo,
                                    output int unsigned hi, output int unsigned fr);
      longint unsigned ratio;
      longint unsigned pos;
      longint unsigned a;
      ratio = (longint'(s - 1) << 16) / longint'(dd);
      pos   = (longint'(d) * ratio) >> 8;
      a     = pos >> 8;
      if (a > s - 1) a = s - 1;
      lo = int'(a);
      hi = (a + 1 < s) ? int'(a + 1) : s - 1;
      fr = int'(pos & 255);
   endfunction

   function automatic pixel_result_type interpolate(int unsigned dx, int unsigned dy);
      pixel_result_type res;
      int unsigned   sw, sh, dw, dh;
      int unsigned   x1, x2, fx, y1, y2, fy;
      int unsigned   a, b, p, q, top, bot, v;
      logic [bir_pkg::PIX_W-1:0] tl, tr, bl, br;
      sw = eff_size(cfg_src_w, bir_pkg::MAX_SRC_WIDTH);
      sh = eff_size(cfg_src_h, bir_pkg::MAX_SRC_HEIGHT);
      dw = eff_size(cfg_dst_w, bir_pkg::MAX_DST_DIM);
      dh = eff_size(cfg_dst_h, bir_pkg::MAX_DST_DIM);
      res.pixel = '0;
      if (!channels_ok()) begin
         res.status = bir_pkg::STATUS_CHANNELS;
         return res;
      end
      if (dx >= dw || dy >= dh) begin
         res.status = bir_pkg::STATUS_RANGE;
         return res;
      end
      axis_map(dx, sw, dw, x1, x2, fx);
      axis_map(dy, sh, dh, y1, y2, fy);
      tl = frame_copy[y1 * bir_pkg::MAX_SRC_WIDTH + x1];
      tr = frame_copy[y1 * bir_pkg::MAX_SRC_WIDTH + x2];
      bl = frame_copy[y2 * bir_pkg::MAX_SRC_WIDTH + x1];
      br = frame_copy[y2 * bir_pkg::MAX_SRC_WIDTH + x2];
      for (int c = 0; c < int'(cfg_ch); c++) begin
         a   = (tl >> (bir_pkg::CH_W * c)) & 255;
         b   = (tr >> (bir_pkg::CH_W * c)) & 255;
         p   = (bl >> (bir_pkg::CH_W * c)) & 255;
         q   = (br >> (bir_pkg::CH_W * c)) & 255;
         top = (a * (256 - fx) + b * fx) >> 8;
         bot = (p * (256 - fx) + q * fx) >> 8;
         v   = (top * (256 - fy) + bot * fy) >> 8;
         if (v > 255) v = 255;
         res.pixel = res.pixel | (bir_pkg::PIX_W'(v) << (bir_pkg::CH_W * c));
      end
      res.status = bir_pkg::STATUS_OK;
      return res;
   endfunction

   task automatic take_request(resize_req_type r);
      if (r.kind == bir_pkg::REQ_LOAD) begin
         if (r.sx < eff_size(cfg_src_w, bir_pkg::MAX_SRC_WIDTH) &&
             r.sy < eff_size(cfg_src_h, bir_pkg::MAX_SRC_HEIGHT))
            frame_copy[int'(r.sy) * bir_pkg::MAX_SRC_WIDTH + r.sx] = r.pix;
      end else begin
         expected_pixels.push_back(interpolate(r.dx, r.dy));
      end
   endtask

   task automatic flag_mismatch(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic write_register(logic [bir_pkg::CSR_IDX_W-1:0] idx, int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[bir_pkg::CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         bir_pkg::CSR_SRC_WIDTH:     cfg_src_w = value[bir_pkg::SRC_DIM_W-1:0];
         bir_pkg::CSR_SRC_HEIGHT:    cfg_src_h = value[bir_pkg::SRC_DIM_W-1:0];
         bir_pkg::CSR_DST_WIDTH:     cfg_dst_w = value[bir_pkg::DST_DIM_W-1:0];
         bir_pkg::CSR_DST_HEIGHT:    cfg_dst_h = value[bir_pkg::DST_DIM_W-1:0];
         bir_pkg::CSR_CHANNEL_COUNT: cfg_ch    = value[bir_pkg::CH_CNT_W-1:0];
         default: ;
      endcase
   endtask

   // Loads never produce a result, so a fixed settle time follows the last response.
   task automatic drain();
      do @(posedge clock);
      while (request_queue.size() != 0 || req_valid || expected_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_load(int unsigned x, int unsigned y, logic [bir_pkg::PIX_W-1:0] pix);
      resize_req_type r;
      r.kind = bir_pkg::REQ_LOAD;
      r.sx   = x[bir_pkg::SRC_COORD_W-1:0];
      r.sy   = y[bir_pkg::SRC_COORD_W-1:0];
      r.pix  = pix;
      r.dx   = bir_pkg::DST_COORD_W'($urandom);
      r.dy   = bir_pkg::DST_COORD_W'($urandom);
      r.calm = gen_calm;
      request_queue.push_back(r);
      if (x < eff_size(cfg_src_w, bir_pkg::MAX_SRC_WIDTH) &&
          y < eff_size(cfg_src_h, bir_pkg::MAX_SRC_HEIGHT)) begin
         loaded[y * bir_pkg::MAX_SRC_WIDTH + x] = 1'b1;
         items_pushed++;
      end
   endtask

   // A compute with valid channels and coordinates is preceded by loads of any neighbor never written.
   task automatic push_compute(int unsigned dx, int unsigned dy);
      resize_req_type r;
      int unsigned x1, x2, fx, y1, y2, fy, nx, ny;
      if (channels_ok() && dx < eff_size(cfg_dst_w, bir_pkg::MAX_DST_DIM) &&
          dy < eff_size(cfg_dst_h, bir_pkg::MAX_DST_DIM)) begin
         axis_map(dx, eff_size(cfg_src_w, bir_pkg::MAX_SRC_WIDTH),
                  eff_size(cfg_dst_w, bir_pkg::MAX_DST_DIM), x1, x2, fx);
         axis_map(dy, eff_size(cfg_src_h, bir_pkg::MAX_SRC_HEIGHT),
                  eff_size(cfg_dst_h, bir_pkg::MAX_DST_DIM), y1, y2, fy);
         for (int i = 0; i < bir_pkg::NB_NUM; i++) begin
            nx = i[0] ? x2 : x1;
            ny = i[1] ? y2 : y1;
            if (!loaded[ny * bir_pkg::MAX_SRC_WIDTH + nx])
               push_load(nx, ny, bir_pkg::PIX_W'($urandom));
         end
      end
      r.kind = bir_pkg::REQ_COMPUTE;
      r.sx   = bir_pkg::SRC_COORD_W'($urandom);
      r.sy   = bir_pkg::SRC_COORD_W'($urandom);
      r.pix  = bir_pkg::PIX_W'($urandom);
      r.dx   = dx[bir_pkg::DST_COORD_W-1:0];
      r.dy   = dy[bir_pkg::DST_COORD_W-1:0];
      r.calm = gen_calm;
      request_queue.push_back(r);
      items_pushed++;
   endtask

   task automatic corner_items();
      int unsigned dw, dh;
      dw = eff_size(cfg_dst_w, bir_pkg::MAX_DST_DIM);
      dh = eff_size(cfg_dst_h, bir_pkg::MAX_DST_DIM);
      push_compute(0, 0);
      push_compute(dw - 1, dh - 1);
      push_compute(dw - 1, 0);
      if (dw < bir_pkg::MAX_DST_DIM) push_compute(dw, 0);
      if (dh < bir_pkg::MAX_DST_DIM) push_compute(0, bir_pkg::MAX_DST_DIM - 1);
   endtask

   task automatic random_traffic(int count);
      int unsigned target, sw, sh, dw, dh, r, px, py;
      target = items_pushed + count;
      sw = eff_size(cfg_src_w, bir_pkg::MAX_SRC_WIDTH);
      sh = eff_size(cfg_src_h, bir_pkg::MAX_SRC_HEIGHT);
      dw = eff_size(cfg_dst_w, bir_pkg::MAX_DST_DIM);
      dh = eff_size(cfg_dst_h, bir_pkg::MAX_DST_DIM);
      while (items_pushed < target) begin
         r = $urandom_range(99);
         if (r < 68) begin
            px = ($urandom_range(7) == 0) ? dw - 1 : $urandom_range(dw - 1);
            py = ($urandom_range(7) == 0) ? dh - 1 : $urandom_range(dh - 1);
            push_compute(px, py);
         end else if (r < 84) begin
            push_load($urandom_range(sw - 1), $urandom_range(sh - 1),
                      bir_pkg::PIX_W'($urandom));
         end else if (r < 92) begin
            // Loads outside the source frame, where it is smaller than the store, must leave the store untouched.
            if (sw < bir_pkg::MAX_SRC_WIDTH)
               push_load($urandom_range(255, sw), $urandom_range(255),
                         bir_pkg::PIX_W'($urandom));
            else if (sh < bir_pkg::MAX_SRC_HEIGHT)
               push_load($urandom_range(255), $urandom_range(255, sh),
                         bir_pkg::PIX_W'($urandom));
            else
               push_load($urandom_range(255), $urandom_range(255),
                         bir_pkg::PIX_W'($urandom));
         end else begin
            px = (dw < bir_pkg::MAX_DST_DIM) ? $urandom_range(bir_pkg::MAX_DST_DIM - 1, dw)
                                             : $urandom_range(bir_pkg::MAX_DST_DIM - 1);
            push_compute(px, $urandom_range(bir_pkg::MAX_DST_DIM - 1));
         end
      end
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall)
            take_request(cur_req);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (request_queue.size() == 0) begin
               req_valid <= 1'b0;
            end else if (!calm_tail && !request_queue[0].calm &&
                         $urandom_range(9) == 0) begin
               gap_left = $urandom_range(6);
               req_valid <= 1'b0;
            end else begin
               cur_req = request_queue.pop_front();
               if (cur_req.calm) calm_tail = 1'b1;
               req_valid    <= 1'b1;
               req_type     <= cur_req.kind;
               req_src_x    <= cur_req.sx;
               req_src_y    <= cur_req.sy;
               req_pixel_in <= cur_req.pix;
               req_dst_x    <= cur_req.dx;
               req_dst_y    <= cur_req.dy;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               flag_mismatch($sformatf("result with nothing pending: pixel_out %h status %0d",
                                       rsp_pixel_out, rsp_status));
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_out !== want.pixel)
                  flag_mismatch($sformatf("pixel_out %h, predicted %h",
                                          rsp_pixel_out, want.pixel));
               if (rsp_status !== want.status)
                  flag_mismatch($sformatf("status %0d, predicted %0d",
                                          rsp_status, want.status));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!calm_tail && $urandom_range(7) == 0) begin
            hold_left = $urandom_range(6);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry: 256x256 to 256x256, four channels, with extreme pixel values.
      push_load(0, 0, 32'hFFFF_FFFF);
      push_load(1, 0, 32'h0000_0000);
      push_load(0, 1, 32'h80FF_00FF);
      push_load(255, 255, 32'hFFFF_FFFF);
      push_load(254, 254, 32'h0000_0000);
      corner_items();
      push_compute(bir_pkg::MAX_DST_DIM - 1, bir_pkg::MAX_DST_DIM - 1);
      random_traffic(100);

      foreach (phase_plan[p]) begin
         drain();
         if (p == $size(phase_plan) - 1) gen_calm = 1'b1;
         write_register(bir_pkg::CSR_SRC_WIDTH, phase_plan[p].sw);
         write_register(bir_pkg::CSR_SRC_HEIGHT, phase_plan[p].sh);
         write_register(bir_pkg::CSR_DST_WIDTH, phase_plan[p].dw);
         write_register(bir_pkg::CSR_DST_HEIGHT, phase_plan[p].dh);
         write_register(bir_pkg::CSR_CHANNEL_COUNT, phase_plan[p].ch);
         corner_items();
         random_traffic(phase_plan[p].count);
      end
      drain();

      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/bir_pkg.sv
rtl/core/bir_ram.sv
rtl/core/bir_divider.sv
rtl/core/bir_lane.sv
rtl/core/bir_merge.sv
rtl/core/bilinear_image_resize.sv
dv/bilinear_image_resize_test.sv
